@@ hdl/ftwm_pkg.sv @@
// ============================================================================
// ftwm_pkg: frame time window monitor shared definitions
// Widths, item types, register indexes, health codes and helpers.
// ============================================================================
package ftwm_pkg;

    localparam int WINDOW_DEPTH  = 64;
    localparam int TIME_BITS     = 20;
    localparam int BUDGET_BITS   = 20;
    localparam int WSIZE_BITS    = 7;
    localparam int PASS_BITS     = 8;
    localparam int CNT_BITS      = $clog2(WINDOW_DEPTH + 1);
    localparam int HEALTH_BITS   = 2;
    localparam int UTIL_BITS     = 16;
    localparam int Q_FRAC        = 8;
    localparam int SLOT_BITS     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_BITS      = TIME_BITS + CNT_BITS;
    localparam int DIV_BITS      = (SUM_BITS > TIME_BITS + Q_FRAC) ? SUM_BITS
                                                                  : TIME_BITS + Q_FRAC;
    localparam int DVS_BITS      = (BUDGET_BITS > CNT_BITS) ? BUDGET_BITS : CNT_BITS;
    localparam int DCNT_BITS     = $clog2(DIV_BITS + 1);
    localparam int PROD_BITS     = CNT_BITS + 7;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS = 20;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BUDGET_TIME = 1'b1;

    localparam logic [WSIZE_BITS-1:0]  WSIZE_RESET  = 7'd64;
    localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = 20'd16667;

    // item codes
    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    // health codes
    localparam logic [HEALTH_BITS-1:0] HEALTH_EXCELLENT = 2'd0;
    localparam logic [HEALTH_BITS-1:0] HEALTH_GOOD      = 2'd1;
    localparam logic [HEALTH_BITS-1:0] HEALTH_WARNING   = 2'd2;
    localparam logic [HEALTH_BITS-1:0] HEALTH_CRITICAL  = 2'd3;

    // violation thresholds in percent
    localparam int PCT_SCALE  = 100;
    localparam int PCT_GOOD   = 5;
    localparam int PCT_WARN   = 15;
    localparam int PCT_CRIT   = 35;

    localparam int UTIL_MAX = (1 << UTIL_BITS) - 1;

    typedef struct packed {
        logic                  func;
        logic [TIME_BITS-1:0]  frame_time;
        logic [PASS_BITS-1:0]  passes_run;
    } ftwm_req_t;

    typedef struct packed {
        logic [CNT_BITS-1:0]    frame_count;
        logic [TIME_BITS-1:0]   mean_time;
        logic [TIME_BITS-1:0]   least_time;
        logic [TIME_BITS-1:0]   most_time;
        logic [PASS_BITS-1:0]   most_passes;
        logic [CNT_BITS-1:0]    over_budget;
        logic [HEALTH_BITS-1:0] health;
        logic [UTIL_BITS-1:0]   utilization;
    } ftwm_rsp_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] duration;
        logic [PASS_BITS-1:0] passes;
    } ftwm_entry_t;

    // window size clamped to 1..WINDOW_DEPTH
    function automatic logic [CNT_BITS-1:0] eff_window(input logic [WSIZE_BITS-1:0] ws);
        logic [CNT_BITS-1:0] w;
        if (ws == '0)
            w = CNT_BITS'(1);
        else if (ws > WSIZE_BITS'(WINDOW_DEPTH))
            w = CNT_BITS'(WINDOW_DEPTH);
        else
            w = CNT_BITS'(ws);
        return w;
    endfunction

endpackage

@@ hdl/ftwm_ring.sv @@
// ============================================================================
// ftwm_ring: frame history memory
// One write port and one registered read port over the duration/pass ring.
// ============================================================================
module ftwm_ring (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ftwm_pkg::SLOT_BITS-1:0] wr_addr,
    input  ftwm_pkg::ftwm_entry_t         wr_data,
    input  logic [ftwm_pkg::SLOT_BITS-1:0] rd_addr,
    output ftwm_pkg::ftwm_entry_t         rd_data
);
    import ftwm_pkg::*;

    ftwm_entry_t mem [WINDOW_DEPTH];
    ftwm_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/ftwm_div.sv @@
// ============================================================================
// ftwm_div: shared unsigned divider
// Restoring divider, one quotient bit per cycle, DIV_BITS steps per division.
// ============================================================================
module ftwm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ftwm_pkg::DIV_BITS-1:0] dividend,
    input  logic [ftwm_pkg::DVS_BITS-1:0] divisor,
    output logic                          busy,
    output logic                          done,
    output logic [ftwm_pkg::DIV_BITS-1:0] quotient
);
    import ftwm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DCNT_BITS-1:0] cnt_reg;
    logic [DIV_BITS-1:0]  quo_reg;
    logic [DVS_BITS-1:0]  rem_reg;
    logic [DVS_BITS-1:0]  dvs_reg;

    logic [DVS_BITS:0]    shifted;
    logic [DVS_BITS:0]    diff;
    logic                 fits;

    // shift in the next dividend bit and try the subtract
    assign shifted = {rem_reg, quo_reg[DIV_BITS-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = ~diff[DVS_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVS_BITS-1:0] : shifted[DVS_BITS-1:0];
            quo_reg <= {quo_reg[DIV_BITS-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DCNT_BITS'(DIV_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/frame_time_window_monitor_top.sv @@
// ============================================================================
// frame_time_window_monitor_top: sliding-window frame time statistics
// Ring of recent frames, scan sequencer and shared divider for mean and
// utilization.
// ============================================================================
//
//  channel   signals                          direction  item
//  req       req_valid req_stall req_item      in         record / clear
//  rsp       rsp_valid rsp_stall rsp_item      out        window statistics
//  cfg       cfg_we cfg_index cfg_data         in         register write
//
//  a record item runs from its acceptance through a scan of frame_count ring
//  entries over the ring's registered read port, two 28-step divisions on the
//  shared divider and the load of the output register before the next item is
//  taken; a zero budget skips the second division; a clear item goes straight
//  to the load of the output register
//  req_stall is high from acceptance until the result is loaded into the
//  output register; a waiting result does not block the next item
//  reset needs no clearing pass; ring entries are read only once written
//
module frame_time_window_monitor_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  ftwm_pkg::ftwm_req_t                  req_item,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output ftwm_pkg::ftwm_rsp_t                  rsp_item,
    input  logic                                 cfg_we,
    input  logic [ftwm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ftwm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import ftwm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_UTIL_GO,
        S_UTIL_WAIT,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [WSIZE_BITS-1:0]   window_size_reg;
    logic [BUDGET_BITS-1:0]  budget_reg;
    logic [SLOT_BITS-1:0]    slot_reg;
    logic [CNT_BITS-1:0]     held_reg;
    logic [SLOT_BITS-1:0]    rd_ptr_reg;
    logic [CNT_BITS-1:0]     issue_reg;
    logic                    rd_pend_reg;
    logic [SUM_BITS-1:0]     sum_reg;
    logic [TIME_BITS-1:0]    least_reg;
    logic [TIME_BITS-1:0]    most_reg;
    logic [PASS_BITS-1:0]    mostp_reg;
    logic [CNT_BITS-1:0]     over_reg;
    logic [TIME_BITS-1:0]    mean_reg;
    logic [UTIL_BITS-1:0]    util_reg;
    logic                    rsp_valid_reg;
    ftwm_rsp_t               rsp_item_reg;

    logic                    accept;
    logic [CNT_BITS-1:0]     win;
    logic [CNT_BITS-1:0]     held_rec;
    logic [CNT_BITS-1:0]     win_cfg;
    logic [SLOT_BITS-1:0]    slot_inc;
    logic [SLOT_BITS-1:0]    ptr_dec;

    logic                    ring_we;
    ftwm_entry_t             ring_wdata;
    ftwm_entry_t             ring_rdata;

    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic [DIV_BITS-1:0]     div_dividend;
    logic [DVS_BITS-1:0]     div_divisor;
    logic [DIV_BITS-1:0]     div_quotient;

    logic [PROD_BITS-1:0]    v100;
    logic [HEALTH_BITS-1:0]  health;
    logic                    out_free;
    ftwm_rsp_t               result;

    assign accept   = req_valid && !req_stall;
    assign win      = eff_window(window_size_reg);
    assign held_rec = (held_reg < win) ? held_reg + 1'b1 : win;
    assign win_cfg  = eff_window(cfg_data[WSIZE_BITS-1:0]);
    assign slot_inc = (slot_reg == SLOT_BITS'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    assign ptr_dec  = (rd_ptr_reg == '0) ? SLOT_BITS'(WINDOW_DEPTH - 1) : rd_ptr_reg - 1'b1;

    assign ring_we             = accept && (req_item.func == FUNC_RECORD);
    assign ring_wdata.duration = req_item.frame_time;
    assign ring_wdata.passes   = req_item.passes_run;

    ftwm_ring u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (slot_reg),
        .wr_data (ring_wdata),
        .rd_addr (rd_ptr_reg),
        .rd_data (ring_rdata)
    );

    assign div_start    = (state_reg == S_MEAN_GO) || (state_reg == S_UTIL_GO);
    assign div_dividend = (state_reg == S_UTIL_GO) ? DIV_BITS'({mean_reg, Q_FRAC'(0)})
                                                   : DIV_BITS'(sum_reg);
    assign div_divisor  = (state_reg == S_UTIL_GO) ? DVS_BITS'(budget_reg)
                                                   : DVS_BITS'(held_reg);

    ftwm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // violation rate against the thresholds, exact in integers
    assign v100 = PROD_BITS'(over_reg) * PROD_BITS'(PCT_SCALE);

    always_comb
    begin
        if (held_reg == '0)
            health = HEALTH_EXCELLENT;
        else if (v100 < PROD_BITS'(held_reg) * PROD_BITS'(PCT_GOOD))
            health = HEALTH_EXCELLENT;
        else if (v100 < PROD_BITS'(held_reg) * PROD_BITS'(PCT_WARN))
            health = HEALTH_GOOD;
        else if (v100 < PROD_BITS'(held_reg) * PROD_BITS'(PCT_CRIT))
            health = HEALTH_WARNING;
        else
            health = HEALTH_CRITICAL;
    end

    always_comb
    begin
        result = '0;
        result.frame_count = held_reg;
        if (held_reg != '0)
        begin
            result.mean_time   = mean_reg;
            result.least_time  = least_reg;
            result.most_time   = most_reg;
            result.most_passes = mostp_reg;
            result.over_budget = over_reg;
            result.health      = health;
            result.utilization = util_reg;
        end
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_size_reg <= WSIZE_RESET;
            budget_reg      <= BUDGET_RESET;
            slot_reg        <= '0;
            held_reg        <= '0;
            rd_ptr_reg      <= '0;
            issue_reg       <= '0;
            rd_pend_reg     <= 1'b0;
            sum_reg         <= '0;
            least_reg       <= '0;
            most_reg        <= '0;
            mostp_reg       <= '0;
            over_reg        <= '0;
            mean_reg        <= '0;
            util_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_item_reg    <= '0;
        end
        else
        begin
            // in S_DONE the output register is reloaded instead
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_SIZE:
                    begin
                        window_size_reg <= cfg_data[WSIZE_BITS-1:0];
                        // shrinking the window drops the oldest frames at once
                        if (held_reg > win_cfg)
                            held_reg <= win_cfg;
                    end
                    CFG_BUDGET_TIME:
                    begin
                        budget_reg <= cfg_data[BUDGET_BITS-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        issue_reg   <= '0;
                        rd_pend_reg <= 1'b0;
                        sum_reg     <= '0;
                        least_reg   <= '1;
                        most_reg    <= '0;
                        mostp_reg   <= '0;
                        over_reg    <= '0;
                        mean_reg    <= '0;
                        util_reg    <= '0;
                        if (req_item.func == FUNC_CLEAR)
                        begin
                            held_reg  <= '0;
                            slot_reg  <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            held_reg   <= held_rec;
                            slot_reg   <= slot_inc;
                            rd_ptr_reg <= slot_reg;
                            state_reg  <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    // newest first: one read issued per cycle, data taken from the registered read port
                    if (issue_reg != held_reg)
                    begin
                        issue_reg  <= issue_reg + 1'b1;
                        rd_ptr_reg <= ptr_dec;
                    end
                    rd_pend_reg <= (issue_reg != held_reg);
                    if (rd_pend_reg)
                    begin
                        sum_reg <= sum_reg + SUM_BITS'(ring_rdata.duration);
                        if (ring_rdata.duration < least_reg)
                            least_reg <= ring_rdata.duration;
                        if (ring_rdata.duration > most_reg)
                            most_reg <= ring_rdata.duration;
                        if (ring_rdata.passes > mostp_reg)
                            mostp_reg <= ring_rdata.passes;
                        if (ring_rdata.duration > budget_reg)
                            over_reg <= over_reg + 1'b1;
                    end
                    if ((issue_reg == held_reg) && !rd_pend_reg)
                        state_reg <= S_MEAN_GO;
                end

                S_MEAN_GO:
                begin
                    state_reg <= S_MEAN_WAIT;
                end

                S_MEAN_WAIT:
                begin
                    if (div_done)
                    begin
                        mean_reg <= div_quotient[TIME_BITS-1:0];
                        if (budget_reg == '0)
                        begin
                            // zero budget saturates any nonzero mean
                            util_reg  <= (div_quotient[TIME_BITS-1:0] != '0) ? '1 : '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_UTIL_GO;
                        end
                    end
                end

                S_UTIL_GO:
                begin
                    state_reg <= S_UTIL_WAIT;
                end

                S_UTIL_WAIT:
                begin
                    if (div_done)
                    begin
                        if (div_quotient > DIV_BITS'(UTIL_MAX))
                            util_reg <= '1;
                        else
                            util_reg <= div_quotient[UTIL_BITS-1:0];
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_item_reg  <= result;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_BITS'(WINDOW_DEPTH))
        else $error("frame count beyond ring depth");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (held_reg != '0) && (issue_reg <= held_reg))
        else $error("scan on empty window or past frame count");

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_MEAN_WAIT) || (state_reg == S_UTIL_WAIT))
        else $error("divider result with nobody waiting");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) && (rsp_item_reg.frame_count == '0) |->
            (rsp_item_reg.mean_time == '0) && (rsp_item_reg.health == HEALTH_EXCELLENT)
            && (rsp_item_reg.utilization == '0))
        else $error("empty window result not zero");

endmodule
